>>> hw/rtl/khpr_pkg.sv
`timescale 1ns / 1ps
package khpr_pkg;

    localparam int KMER_BITS_DEF = 64;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int FIFO_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PASS_COUNT      = 2'd0,
        REG_CURRENT_PASS    = 2'd1,
        REG_PARTITION_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] pass_count;
        logic [CFG_W-1:0] current_pass;
        logic [CFG_W-1:0] partition_count;
    } khpr_cfg_t;

endpackage

>>> hw/rtl/khpr_div_stage.sv
`timescale 1ns / 1ps
// One restoring division step: one dividend bit in, one quotient bit out.
module khpr_div_stage #(
    parameter int W = khpr_pkg::KMER_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid_in,
    input  logic [W-1:0]               kmer_in,
    input  logic [W-1:0]               work_in,
    input  logic [khpr_pkg::CFG_W-1:0] rem_in,
    input  logic [khpr_pkg::CFG_W-1:0] divisor,
    output logic                       valid_out,
    output logic [W-1:0]               kmer_out,
    output logic [W-1:0]               work_out,
    output logic [khpr_pkg::CFG_W-1:0] rem_out
);
    import khpr_pkg::*;

    logic [CFG_W:0]   shifted;
    logic [CFG_W:0]   diff;
    logic             ge;
    logic [CFG_W-1:0] rem_next;
    logic [W-1:0]     work_next;
    logic             valid_reg;
    logic [W-1:0]     kmer_reg;
    logic [W-1:0]     work_reg;
    logic [CFG_W-1:0] rem_reg;

    always_comb
    begin
        shifted   = {rem_in, work_in[W-1]};
        diff      = shifted - {1'b0, divisor};
        ge        = (shifted >= {1'b0, divisor});
        rem_next  = ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
        work_next = {work_in[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        kmer_reg <= kmer_in;
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign valid_out = valid_reg;
    assign kmer_out  = kmer_reg;
    assign work_out  = work_reg;
    assign rem_out   = rem_reg;

endmodule

>>> hw/rtl/khpr_front.sv
`timescale 1ns / 1ps
// Hash, divide by pass count, keep items of the current pass.
module khpr_front #(
    parameter int W = khpr_pkg::KMER_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [W-1:0]        kmer,
    input  khpr_pkg::khpr_cfg_t cfg,
    output logic                push,
    output logic [W-1:0]        push_kmer,
    output logic [W-1:0]        push_quot
);
    import khpr_pkg::*;

    logic [W-1:0] a0, a1, a2, a3;
    logic [W-1:0] b0, b1, b2;
    logic         h1_valid_reg;
    logic [W-1:0] h1_kmer_reg;
    logic [W-1:0] h1_reg;
    logic         h2_valid_reg;
    logic [W-1:0] h2_kmer_reg;
    logic [W-1:0] h2_reg;

    logic             v_s    [0:W];
    logic [W-1:0]     kmer_s [0:W];
    logic [W-1:0]     work_s [0:W];
    logic [CFG_W-1:0] rem_s  [0:W];

    always_comb
    begin
        a0 = kmer ^ (kmer >> 14);
        a1 = (~a0) + (a0 << 18);
        a2 = a1 ^ (a1 >> 31);
        a3 = (a2 << 4) + (a2 << 2) + a2;
        b0 = h1_reg ^ (h1_reg >> 11);
        b1 = b0 + (b0 << 6);
        b2 = b1 ^ (b1 >> 22);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_valid_reg <= 1'b0;
            h2_valid_reg <= 1'b0;
        end
        else
        begin
            h1_valid_reg <= in_valid;
            h2_valid_reg <= h1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h1_kmer_reg <= kmer;
        h1_reg      <= a3;
        h2_kmer_reg <= h1_kmer_reg;
        h2_reg      <= b2;
    end

    assign v_s[0]    = h2_valid_reg;
    assign kmer_s[0] = h2_kmer_reg;
    assign work_s[0] = h2_reg;
    assign rem_s[0]  = '0;

    for (genvar i = 0; i < W; i++)
    begin : g_div
        khpr_div_stage #(.W(W)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (v_s[i]),
            .kmer_in   (kmer_s[i]),
            .work_in   (work_s[i]),
            .rem_in    (rem_s[i]),
            .divisor   (cfg.pass_count),
            .valid_out (v_s[i+1]),
            .kmer_out  (kmer_s[i+1]),
            .work_out  (work_s[i+1]),
            .rem_out   (rem_s[i+1])
        );
    end

    assign push      = v_s[W] && (cfg.pass_count != '0) && (rem_s[W] == cfg.current_pass);
    assign push_kmer = kmer_s[W];
    assign push_quot = work_s[W];

endmodule

>>> hw/rtl/khpr_fifo.sv
`timescale 1ns / 1ps
module khpr_fifo #(
    parameter int W = khpr_pkg::KMER_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_kmer,
    input  logic [W-1:0] push_quot,
    input  logic         pop,
    output logic         empty,
    output logic         full,
    output logic [W-1:0] head_kmer,
    output logic [W-1:0] head_quot
);
    import khpr_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [W-1:0]     kmer_mem [0:FIFO_DEPTH-1];
    logic [W-1:0]     quot_mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kmer_mem[wr_ptr_reg] <= push_kmer;
            quot_mem[wr_ptr_reg] <= push_quot;
        end
    end

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_kmer = kmer_mem[rd_ptr_reg];
    assign head_quot = quot_mem[rd_ptr_reg];

endmodule

>>> hw/rtl/khpr_back.sv
`timescale 1ns / 1ps
// Quotient modulo partition count.
module khpr_back #(
    parameter int W = khpr_pkg::KMER_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [W-1:0]               in_kmer,
    input  logic [W-1:0]               in_quot,
    input  khpr_pkg::khpr_cfg_t        cfg,
    output logic                       strobe,
    output logic [W-1:0]               kmer_out,
    output logic [khpr_pkg::CFG_W-1:0] partition
);
    import khpr_pkg::*;

    logic             v_s    [0:W];
    logic [W-1:0]     kmer_s [0:W];
    logic [W-1:0]     work_s [0:W];
    logic [CFG_W-1:0] rem_s  [0:W];

    assign v_s[0]    = in_valid;
    assign kmer_s[0] = in_kmer;
    assign work_s[0] = in_quot;
    assign rem_s[0]  = '0;

    for (genvar i = 0; i < W; i++)
    begin : g_mod
        khpr_div_stage #(.W(W)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (v_s[i]),
            .kmer_in   (kmer_s[i]),
            .work_in   (work_s[i]),
            .rem_in    (rem_s[i]),
            .divisor   (cfg.partition_count),
            .valid_out (v_s[i+1]),
            .kmer_out  (kmer_s[i+1]),
            .work_out  (work_s[i+1]),
            .rem_out   (rem_s[i+1])
        );
    end

    assign strobe    = v_s[W];
    assign kmer_out  = kmer_s[W];
    assign partition = (cfg.partition_count == '0) ? '0 : rem_s[W];

endmodule

>>> hw/rtl/kmer_hash_partition_router.sv
`timescale 1ns / 1ps
// Routes k-mers to partitions: one k-mer accepted every cycle (busy stays low).
// Each k-mer passes the hash registers and a bit-per-stage divider pipeline
// (hash mod/div pass_count); kept k-mers pass the FIFO and a second such
// pipeline (quotient mod partition_count) to strobe. K-mers not in current_pass
// produce no strobe. strobe is high for one cycle per result and cannot be held
// off. Write configuration only while no items are in flight.
module kmer_hash_partition_router #(
    parameter int KMER_BITS = khpr_pkg::KMER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [KMER_BITS-1:0]           kmer,
    input  logic                           cfg_we,
    input  logic [khpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [khpr_pkg::CFG_W-1:0]     cfg_data,
    output logic                           strobe,
    output logic [KMER_BITS-1:0]           kmer_out,
    output logic [khpr_pkg::CFG_W-1:0]     partition
);
    import khpr_pkg::*;

    khpr_cfg_t          cfg_reg;
    logic               push, pop, empty, full;
    logic [KMER_BITS-1:0] push_kmer, push_quot, head_kmer, head_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pass_count      <= CFG_W'(1);
            cfg_reg.current_pass    <= '0;
            cfg_reg.partition_count <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PASS_COUNT:      cfg_reg.pass_count      <= cfg_data;
                REG_CURRENT_PASS:    cfg_reg.current_pass    <= cfg_data;
                REG_PARTITION_COUNT: cfg_reg.partition_count <= cfg_data;
                default:             ;
            endcase
        end
    end

    khpr_front #(.W(KMER_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .kmer      (kmer),
        .cfg       (cfg_reg),
        .push      (push),
        .push_kmer (push_kmer),
        .push_quot (push_quot)
    );

    khpr_fifo #(.W(KMER_BITS)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_kmer (push_kmer),
        .push_quot (push_quot),
        .pop       (pop),
        .empty     (empty),
        .full      (full),
        .head_kmer (head_kmer),
        .head_quot (head_quot)
    );

    assign pop  = !empty;
    assign busy = full;

    khpr_back #(.W(KMER_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pop),
        .in_kmer   (head_kmer),
        .in_quot   (head_quot),
        .cfg       (cfg_reg),
        .strobe    (strobe),
        .kmer_out  (kmer_out),
        .partition (partition)
    );

endmodule

>>> hw/rtl/khpr_checker.sv
`timescale 1ns / 1ps
module khpr_checker #(
    parameter int KMER_BITS = khpr_pkg::KMER_BITS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [KMER_BITS-1:0]           kmer,
    input logic                           cfg_we,
    input logic [khpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [khpr_pkg::CFG_W-1:0]     cfg_data,
    input logic                           strobe,
    input logic [KMER_BITS-1:0]           kmer_out,
    input logic [khpr_pkg::CFG_W-1:0]     partition
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    a_no_strobe_in_reset: assert property (@(posedge clk) !rst_n |=> !strobe)
        else $error("strobe during reset");

    a_no_strobe_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> !strobe)
        else $error("strobe right after reset");

endmodule

bind kmer_hash_partition_router khpr_checker #(.KMER_BITS(KMER_BITS)) u_khpr_checker (.*);
